// File: rtl/gsp_pkg.sv
`default_nettype none

package gsp_pkg;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PLAIN,
    KIND_ESC
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] septet;
  } class_t;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] septet;
    logic       last;
  } item_t;

  localparam logic [6:0] ESCAPE_SEPTET = 7'h1B;

  // Maps a UCS-2 code unit to its septet in the default alphabet, or to its
  // extension code behind the escape septet.
  function automatic class_t classify(logic [15:0] code);
    class_t r;
    r.kind   = KIND_PLAIN;
    r.septet = code[6:0];
    if ((code >= 16'h0020 && code <= 16'h0023) || (code >= 16'h0025 && code <= 16'h003F) ||
        (code >= 16'h0041 && code <= 16'h005A) || (code >= 16'h0061 && code <= 16'h007A) ||
        code == 16'h000A || code == 16'h000D) begin
      r.septet = code[6:0];
    end else begin
      case (code)
        16'h0040: r.septet = 7'h00;
        16'h00A3: r.septet = 7'h01;
        16'h0024: r.septet = 7'h02;
        16'h00A5: r.septet = 7'h03;
        16'h00E8: r.septet = 7'h04;
        16'h00E9: r.septet = 7'h05;
        16'h00F9: r.septet = 7'h06;
        16'h00EC: r.septet = 7'h07;
        16'h00F2: r.septet = 7'h08;
        16'h00C7: r.septet = 7'h09;
        16'h00D8: r.septet = 7'h0B;
        16'h00F8: r.septet = 7'h0C;
        16'h00C5: r.septet = 7'h0E;
        16'h00E5: r.septet = 7'h0F;
        16'h0394: r.septet = 7'h10;
        16'h005F: r.septet = 7'h11;
        16'h03A6: r.septet = 7'h12;
        16'h0393: r.septet = 7'h13;
        16'h039B: r.septet = 7'h14;
        16'h03A9: r.septet = 7'h15;
        16'h03A0: r.septet = 7'h16;
        16'h03A8: r.septet = 7'h17;
        16'h03A3: r.septet = 7'h18;
        16'h0398: r.septet = 7'h19;
        16'h039E: r.septet = 7'h1A;
        16'h00C6: r.septet = 7'h1C;
        16'h00E6: r.septet = 7'h1D;
        16'h00DF: r.septet = 7'h1E;
        16'h00C9: r.septet = 7'h1F;
        16'h00A4: r.septet = 7'h24;
        16'h00A1: r.septet = 7'h40;
        16'h00C4: r.septet = 7'h5B;
        16'h00D6: r.septet = 7'h5C;
        16'h00D1: r.septet = 7'h5D;
        16'h00DC: r.septet = 7'h5E;
        16'h00A7: r.septet = 7'h5F;
        16'h00BF: r.septet = 7'h60;
        16'h00E4: r.septet = 7'h7B;
        16'h00F6: r.septet = 7'h7C;
        16'h00F1: r.septet = 7'h7D;
        16'h00FC: r.septet = 7'h7E;
        16'h00E0: r.septet = 7'h7F;
        16'h000C: begin r.kind = KIND_ESC; r.septet = 7'h0A; end
        16'h005E: begin r.kind = KIND_ESC; r.septet = 7'h14; end
        16'h007B: begin r.kind = KIND_ESC; r.septet = 7'h28; end
        16'h007D: begin r.kind = KIND_ESC; r.septet = 7'h29; end
        16'h005C: begin r.kind = KIND_ESC; r.septet = 7'h2F; end
        16'h005B: begin r.kind = KIND_ESC; r.septet = 7'h3C; end
        16'h007E: begin r.kind = KIND_ESC; r.septet = 7'h3D; end
        16'h005D: begin r.kind = KIND_ESC; r.septet = 7'h3E; end
        16'h007C: begin r.kind = KIND_ESC; r.septet = 7'h40; end
        16'h20AC: begin r.kind = KIND_ESC; r.septet = 7'h65; end
        default: begin r.kind = KIND_NONE; r.septet = 7'h00; end
      endcase
    end
    return r;
  endfunction

  // Fill bits that align the first septet after a header and its length octet.
  // Since 8 is 1 modulo 7, the residue is the sum of the octal digits.
  function automatic logic [3:0] fill_bits(logic [7:0] hdr_len);
    logic [8:0] x;
    logic [4:0] s;
    logic [3:0] t;
    logic [2:0] r;
    logic [3:0] f;
    x = {1'b0, hdr_len} + 9'd1;
    s = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]);
    t = 4'(s[2:0]) + 4'(s[4:3]);
    r = (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
    if (hdr_len == 8'd0 || r == 3'd0) begin
      f = 4'd0;
    end else begin
      f = 4'd7 - 4'(r);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// File: rtl/gsp_fifo.sv
`default_nettype none

module gsp_fifo #(
  parameter int Width = 10,
  parameter int Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gsp_front.sv
`default_nettype none

module gsp_front (
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [15:0]  s_axis_tdata_i,
  input  wire logic         s_axis_tlast_i,
  input  wire logic         q_full_i,
  output logic              q_push_o,
  output gsp_pkg::item_t    q_item_o
);

  gsp_pkg::class_t cls;

  assign cls             = gsp_pkg::classify(s_axis_tdata_i);
  assign s_axis_tready_o = !q_full_i;

  // A dropped character only matters when it closes the message.
  assign q_push_o = s_axis_tvalid_i && !q_full_i &&
                    (cls.kind != gsp_pkg::KIND_NONE || s_axis_tlast_i);

  always_comb begin
    q_item_o.kind   = cls.kind;
    q_item_o.septet = cls.septet;
    q_item_o.last   = s_axis_tlast_i;
  end

endmodule

`default_nettype wire

// File: rtl/gsp_back.sv
`default_nettype none

module gsp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [7:0]     cfg_wdata_i,
  input  wire gsp_pkg::item_t q_item_i,
  input  wire logic           q_empty_i,
  output logic                q_pop_o,
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_FLUSH  = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  fill_q;
  logic [7:0]  buf_q, buf_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        start_q, start_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q;
  logic        out_last_q;

  logic        fire, is_flush, done, emit, emit_last;
  logic [6:0]  septet;
  logic [7:0]  base_buf;
  logic [3:0]  base_cnt, new_cnt;
  logic [14:0] merged;
  logic [7:0]  emit_data;

  assign fire = !q_empty_i && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    is_flush = 1'b0;
    done     = 1'b0;
    septet   = q_item_i.septet;
    case (phase_q)
      PH_FIRST: begin
        if (q_item_i.kind == gsp_pkg::KIND_NONE) begin
          is_flush = 1'b1;
          done     = 1'b1;
        end else if (q_item_i.kind == gsp_pkg::KIND_ESC) begin
          septet = gsp_pkg::ESCAPE_SEPTET;
        end else begin
          done = !q_item_i.last;
        end
      end
      PH_SECOND: begin
        done = !q_item_i.last;
      end
      default: begin
        is_flush = 1'b1;
        done     = 1'b1;
      end
    endcase
  end

  always_comb begin
    base_buf = start_q ? 8'd0 : buf_q;
    base_cnt = start_q ? fill_q : cnt_q;
    merged   = {7'd0, base_buf} | (15'(septet) << base_cnt);
    new_cnt  = base_cnt + 4'd7;

    buf_d     = buf_q;
    cnt_d     = cnt_q;
    start_d   = start_q;
    phase_d   = phase_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_data = merged[7:0];

    if (fire) begin
      if (is_flush) begin
        emit      = !start_q;
        emit_last = 1'b1;
        emit_data = buf_q;
        buf_d     = 8'd0;
        cnt_d     = 4'd0;
        start_d   = 1'b1;
      end else begin
        start_d = 1'b0;
        if (new_cnt > 4'd8) begin
          emit  = 1'b1;
          buf_d = merged[14:8] == 7'd0 ? 8'd0 : {1'b0, merged[14:8]};
          cnt_d = new_cnt - 4'd8;
        end else begin
          buf_d = merged[7:0];
          cnt_d = new_cnt;
        end
      end
      if (done) begin
        phase_d = PH_FIRST;
      end else if (phase_q == PH_FIRST && q_item_i.kind == gsp_pkg::KIND_ESC) begin
        phase_d = PH_SECOND;
      end else begin
        phase_d = PH_FLUSH;
      end
    end

    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign q_pop_o = fire && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      fill_q      <= 4'd0;
      buf_q       <= 8'd0;
      cnt_q       <= 4'd0;
      start_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        fill_q <= gsp_pkg::fill_bits(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_data_q <= emit_data;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// File: rtl/gsm7_septet_packer_core.sv
// A plain character that completes an octet passes the queue, then the output register.
// Throughput: one plain character per cycle while neither queue nor output stalls; an escaped
// character packs as the escape septet, then its code; a closing one adds a final flush.
// Behind a small queue, the packing stage does one septet or flush per cycle unless stalled.
// Reset clears the queue, the bit buffer and the output valid flag; the header length reads as
// zero and the next character starts a new message.
`default_nettype none

module gsm7_septet_packer_core #(
  parameter int FifoDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,      // header_length
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // char_code
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // packed_octet
  output logic             m_axis_tlast_o
);

  localparam int ItemW = $bits(gsp_pkg::item_t);

  gsp_pkg::item_t push_item, head_item;
  logic           q_push, q_full, q_pop, q_empty;

  gsp_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (push_item)
  );

  gsp_fifo #(
    .Width (ItemW),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (head_item),
    .empty_o (q_empty)
  );

  gsp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_item_i        (head_item),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
